// ===== rtl/imd_pkg.sv =====
// Shared types for the integer matrix determinant core.
// No dependencies; used by the top level for its sequencer state.
`timescale 1ns / 1ps
package imd_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUB_START,
        ST_TERM_RD,
        ST_TERM_EL,
        ST_MAC
    } t_state;

endpackage

// ===== rtl/imd_ram.sv =====
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the element store and the minor store; no dependencies.
`timescale 1ns / 1ps
module imd_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/integer_matrix_determinant_core.sv =====
// Top level of the integer matrix determinant core: loader, sequencer and
// chunk-serial multiply-accumulate. Depends on imd_pkg and imd_ram.
`timescale 1ns / 1ps
// Usage
// The matrix size is written on the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_data) while the core is idle; a write also drops any
// partly loaded matrix. Elements arrive in row-major order, one beat per
// cycle, taken whenever i_start is high, o_busy is low and no configuration
// write is accepted at the same time.
// After the last element the core raises o_busy and works through every
// column subset of the matrix, building each minor from the smaller ones held
// in the minor RAM. Each term is a wide multiply-accumulate done one 32-bit
// chunk per cycle over the NCH chunks of the wide word (9 with the default
// parameters).
// The result (low 64 bits and an overflow flag) is shown for one cycle with
// o_result_valid high; the receiver cannot stall it. o_busy falls in that
// same cycle, so the next matrix may start loading at once.
// Reset sets the size to 3 and clears the element count; no clearing pass
// is needed, as every stored entry is written before it is read.
module integer_matrix_determinant_core #(
    parameter int MAX_SIZE     = 12,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic [ELEMENT_BITS-1:0] i_element_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [3:0]              i_cfg_data,
    output logic                    o_result_valid,
    output logic [63:0]             o_determinant_value,
    output logic                    o_overflow
);

    localparam int NCH  = (MAX_SIZE * (ELEMENT_BITS + 4)) / 32 + 2;
    localparam int CW   = $clog2(NCH);
    localparam int CCW  = $clog2(NCH + 1);
    localparam int AW   = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int CNTW = $clog2(MAX_SIZE * MAX_SIZE + 1);
    localparam int NW   = $clog2(MAX_SIZE + 1);
    localparam int JW   = $clog2(MAX_SIZE);
    localparam int SW   = MAX_SIZE;
    localparam int MW   = 32 + ELEMENT_BITS;

    imd_pkg::t_state r_state, n_state;

    logic [3:0]              r_size;
    logic [CNTW-1:0]         r_cnt;
    logic [SW-1:0]           r_s, r_rem, r_sm;
    logic [NW-1:0]           r_row;
    logic [JW-1:0]           r_j;
    logic                    r_pos, r_first, r_last, r_unit, r_sub;
    logic [ELEMENT_BITS-1:0] r_mag;
    logic [CCW-1:0]          r_c;
    logic [ELEMENT_BITS-1:0] r_mcar;
    logic                    r_car, r_sgn, r_ovf;
    logic [31:0]             r_acc [NCH];
    logic [63:0]             r_det;
    logic                    r_res_vld;

    logic [NW-1:0]           act_n;
    logic [CNTW-1:0]         total;
    logic [SW-1:0]           full;
    logic                    load_acc, cfg_acc, load_last;
    logic [JW-1:0]           low_j;
    logic [NW-1:0]           pop;
    logic [AW-1:0]           el_raddr;
    logic [ELEMENT_BITS-1:0] el_q;
    logic [31:0]             mn_q, mchunk, tchunk, accv;
    logic [CW-1:0]           pc;
    logic [MW-1:0]           prod;
    logic [32:0]             sum;
    logic                    cin, proc, mn_we, term_end, sub_done;
    logic [SW-1:0]           jbit;

    // Active size, clamped into range.
    always_comb begin
        if (r_size < 4'd2) begin
            act_n = NW'(2);
        end else if (int'(r_size) > MAX_SIZE) begin
            act_n = NW'(MAX_SIZE);
        end else begin
            act_n = NW'(r_size);
        end
    end

    assign total     = CNTW'(act_n) * CNTW'(act_n);
    assign full      = SW'((1 << act_n) - 1);
    assign load_acc  = i_start && !o_busy;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign load_last = load_acc && !cfg_acc && ((r_cnt + 1'b1) == total);

    always_comb begin
        low_j = '0;
        for (int i = SW - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                low_j = JW'(i);
            end
        end
    end

    always_comb begin
        pop = '0;
        for (int i = 0; i < SW; i++) begin
            pop = pop + NW'(r_s[i]);
        end
    end

    assign el_raddr = AW'(r_row) * AW'(act_n) + AW'(low_j);
    assign jbit     = SW'(1) << r_j;

    // Chunk datapath: term chunk times magnitude, then add or subtract.
    assign proc   = (r_state == imd_pkg::ST_MAC) && (r_c != '0);
    assign pc     = CW'(r_c - 1'b1);
    assign mchunk = r_unit ? ((pc == '0) ? 32'd1 : 32'd0) : mn_q;
    assign prod   = MW'(mchunk) * MW'(r_mag) + MW'(r_mcar);
    assign tchunk = prod[31:0];
    assign accv   = r_first ? 32'd0 : r_acc[pc];
    assign cin    = (pc == '0) ? r_sub : r_car;
    assign sum    = {1'b0, accv} + {1'b0, (r_sub ? ~tchunk : tchunk)} + 33'(cin);
    assign mn_we  = proc && r_last;
    assign term_end = (r_state == imd_pkg::ST_MAC) && (r_c == CCW'(NCH));
    assign sub_done = term_end && r_last;

    imd_ram #(.ADDR_BITS(AW), .DATA_BITS(ELEMENT_BITS)) u_el_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && !cfg_acc),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_element_value),
        .i_raddr (el_raddr),
        .o_rdata (el_q)
    );

    imd_ram #(.ADDR_BITS(SW + CW), .DATA_BITS(32)) u_minor_ram (
        .i_clk   (i_clk),
        .i_we    (mn_we),
        .i_waddr ({r_s, pc}),
        .i_wdata (sum[31:0]),
        .i_raddr ({r_sm, r_c[CW-1:0]}),
        .o_rdata (mn_q)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            imd_pkg::ST_LOAD: begin
                if (load_last) begin
                    n_state = imd_pkg::ST_SUB_START;
                end
            end
            imd_pkg::ST_SUB_START: n_state = imd_pkg::ST_TERM_RD;
            imd_pkg::ST_TERM_RD:   n_state = imd_pkg::ST_TERM_EL;
            imd_pkg::ST_TERM_EL:   n_state = imd_pkg::ST_MAC;
            imd_pkg::ST_MAC: begin
                if (term_end) begin
                    if (!r_last) begin
                        n_state = imd_pkg::ST_TERM_RD;
                    end else if (r_s == full) begin
                        n_state = imd_pkg::ST_LOAD;
                    end else begin
                        n_state = imd_pkg::ST_SUB_START;
                    end
                end
            end
            default: n_state = imd_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        case (r_state)
            imd_pkg::ST_LOAD: begin
                o_busy      = 1'b0;
                o_cfg_ready = 1'b1;
            end
            default: begin
                o_busy      = 1'b1;
                o_cfg_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= imd_pkg::ST_LOAD;
            r_size    <= 4'd3;
            r_cnt     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= sub_done && (r_s == full);
            if (cfg_acc) begin
                r_size <= i_cfg_data;
                r_cnt  <= '0;
            end else if (load_acc) begin
                r_cnt <= load_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_last) begin
            r_s <= SW'(1);
        end else if (sub_done) begin
            r_s <= r_s + 1'b1;
        end
        case (r_state)
            imd_pkg::ST_SUB_START: begin
                r_rem   <= r_s;
                r_pos   <= 1'b0;
                r_first <= 1'b1;
                r_row   <= act_n - pop;
            end
            imd_pkg::ST_TERM_RD: begin
                r_j <= low_j;
            end
            imd_pkg::ST_TERM_EL: begin
                r_sm   <= r_s & ~jbit;
                r_unit <= (r_s & ~jbit) == '0;
                r_last <= (r_rem & ~jbit) == '0;
                r_mag  <= el_q[ELEMENT_BITS-1] ? (~el_q + 1'b1) : el_q;
                // Cofactor sign alternates with the column's place in the subset.
                r_sub  <= el_q[ELEMENT_BITS-1] ^ r_pos;
                r_mcar <= '0;
                r_c    <= '0;
            end
            imd_pkg::ST_MAC: begin
                r_c <= r_c + 1'b1;
                if (term_end) begin
                    r_rem   <= r_rem & ~jbit;
                    r_pos   <= ~r_pos;
                    r_first <= 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (proc) begin
            r_mcar    <= prod[MW-1:32];
            r_car     <= sum[32];
            r_acc[pc] <= sum[31:0];
            if (r_last && (r_s == full)) begin
                if (pc == CW'(0)) begin
                    r_det[31:0] <= sum[31:0];
                end else if (pc == CW'(1)) begin
                    r_det[63:32] <= sum[31:0];
                    r_sgn        <= sum[31];
                    r_ovf        <= 1'b0;
                end else if (sum[31:0] != {32{r_sgn}}) begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    assign o_result_valid      = r_res_vld;
    assign o_determinant_value = r_det;
    assign o_overflow          = r_ovf;

endmodule
